@@ hdl/mcdf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcdf_pkg
// Shared sizes, command codes and helpers for the duplex byte FIFO pool.
// ----------------------------------------------------------------------------
package mcdf_pkg;

  // pool geometry
  localparam int SLOTS      = 8;
  localparam int RING_DEPTH = 4096;
  localparam int RINGS      = 2 * SLOTS;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RING_W = SLOT_W + 1;
  localparam int PTR_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int MEM_DEPTH = RINGS * RING_DEPTH;
  localparam int ADDR_W = $clog2(MEM_DEPTH);

  // port field widths
  localparam int CMD_W   = 4;
  localparam int SLOTF_W = 3;
  localparam int ID_W    = 32;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 13;

  typedef enum logic [CMD_W-1:0] {
    CMD_OPEN        = 4'd0,
    CMD_CLOSE       = 4'd1,
    CMD_ATTACH      = 4'd2,
    CMD_DETACH      = 4'd3,
    CMD_HOST_WRITE  = 4'd4,
    CMD_HOST_READ   = 4'd5,
    CMD_SLAVE_WRITE = 4'd6,
    CMD_SLAVE_READ  = 4'd7,
    CMD_QUERY       = 4'd8
  } cmd_e;

  // ring pointer advance with wrap
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) r = '0;
    else r = p + 1'b1;
    return r;
  endfunction

endpackage

@@ hdl/mcdf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcdf_ram
// Generic single-port RAM, synchronous write, registered read.
// ----------------------------------------------------------------------------
module mcdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/multi_channel_duplex_byte_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_duplex_byte_fifo
// Pool of channels with two byte rings each, driven by one command a request.
// ----------------------------------------------------------------------------
// Each request carries one command and yields one response. Open, close,
// attach, detach, query, byte writes and refused reads have their response
// registered as they are accepted; a read that pops a byte is answered from
// the read state, since the popped byte comes out of the registered read port
// of the shared ring RAM. Only one request is in work at a time; the response
// register frees as soon as its content is taken, so a new request may be
// accepted in the same cycle. Ring pointers, fill counts, used flags and
// owners sit in flops and are cleared by reset; the ring RAM needs no
// clearing, since only pushed entries are ever read back.
// ----------------------------------------------------------------------------
module multi_channel_duplex_byte_fifo
  import mcdf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [CMD_W-1:0]   cmd_i,
  input  logic [SLOTF_W-1:0] slot_i,
  input  logic [ID_W-1:0]    owner_id_i,
  input  logic [BYTE_W-1:0]  byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               ok_o,
  output logic [SLOTF_W-1:0] slot_out_o,
  output logic [BYTE_W-1:0]  byte_out_o,
  output logic               is_open_o,
  output logic               attached_o,
  output logic [COUNT_W-1:0] to_slave_count_o,
  output logic [COUNT_W-1:0] to_host_count_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // control state
  logic              state_q, state_d;
  logic [SLOTS-1:0]  used_q;
  logic [ID_W-1:0]   owner_q  [SLOTS];
  logic [PTR_W-1:0]  wr_ptr_q [RINGS];
  logic [PTR_W-1:0]  rd_ptr_q [RINGS];
  logic [CNT_W-1:0]  cnt_q    [RINGS];

  // response registers
  logic               out_valid_q;
  logic               ok_q;
  logic [SLOTF_W-1:0] slot_out_q;
  logic [BYTE_W-1:0]  byte_out_q;
  logic               is_open_q;
  logic               attached_q;
  logic [COUNT_W-1:0] c0_q;
  logic [COUNT_W-1:0] c1_q;

  logic in_acc;
  logic out_take;

  // decoded request
  logic              slot_valid;
  logic [SLOT_W-1:0] slot_idx;
  logic              used;
  logic              owner_match;
  logic              ring_dir;
  logic [RING_W-1:0] cur_ring;
  logic [CNT_W-1:0]  cur_cnt;
  logic              ring_full;
  logic              ring_empty;
  logic              free_found;
  logic [SLOT_W-1:0] free_idx;

  logic               res_ok;
  logic [SLOTF_W-1:0] res_slot;
  logic               res_iso;
  logic               res_att;
  logic [COUNT_W-1:0] res_c0;
  logic [COUNT_W-1:0] res_c1;
  logic               do_claim;
  logic               do_release;
  logic               do_attach;
  logic               do_detach;
  logic               do_push;
  logic               do_pop;

  logic [ADDR_W-1:0]  ram_addr;
  logic [BYTE_W-1:0]  ram_rdata;

  // handshake
  assign out_take   = out_valid_q && !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  // addressed slot and ring
  assign slot_valid  = 32'(slot_i) < SLOTS;
  assign slot_idx    = SLOT_W'(slot_i);
  assign used        = slot_valid && used_q[slot_idx];
  assign owner_match = owner_q[slot_idx] == owner_id_i;
  assign ring_dir    = (cmd_i == CMD_HOST_READ) || (cmd_i == CMD_SLAVE_WRITE);
  assign cur_ring    = {slot_idx, ring_dir};
  assign cur_cnt     = cnt_q[cur_ring];
  assign ring_full   = cur_cnt >= CNT_W'(RING_DEPTH);
  assign ring_empty  = cur_cnt == '0;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // command decode and response
  always_comb begin
    res_ok     = 1'b0;
    res_slot   = '0;
    res_iso    = 1'b0;
    res_att    = 1'b0;
    res_c0     = '0;
    res_c1     = '0;
    do_claim   = 1'b0;
    do_release = 1'b0;
    do_attach  = 1'b0;
    do_detach  = 1'b0;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    unique case (cmd_i)
      CMD_OPEN: begin
        if (free_found) begin
          do_claim = 1'b1;
          res_ok   = 1'b1;
          res_slot = SLOTF_W'(free_idx);
        end
      end
      CMD_CLOSE: begin
        do_release = used;
        res_ok     = used;
      end
      CMD_ATTACH: begin
        if (owner_id_i != '0 && used && (owner_q[slot_idx] == '0 || owner_match)) begin
          do_attach = 1'b1;
          res_ok    = 1'b1;
        end
      end
      CMD_DETACH: begin
        do_detach = owner_id_i != '0;
        res_ok    = 1'b1;
      end
      CMD_HOST_WRITE: begin
        do_push = used && !ring_full;
        res_ok  = do_push;
      end
      CMD_HOST_READ: begin
        do_pop = used && !ring_empty;
        res_ok = do_pop;
      end
      CMD_SLAVE_WRITE: begin
        do_push = used && owner_match && !ring_full;
        res_ok  = do_push;
      end
      CMD_SLAVE_READ: begin
        do_pop = used && owner_match && !ring_empty;
        res_ok = do_pop;
      end
      CMD_QUERY: begin
        res_ok  = slot_valid;
        res_iso = used;
        res_att = used && owner_match;
        if (used) begin
          res_c0 = COUNT_W'(cnt_q[{slot_idx, 1'b0}]);
          res_c1 = COUNT_W'(cnt_q[{slot_idx, 1'b1}]);
        end
      end
      default: begin
      end
    endcase
  end

  // ring RAM: push writes, pop reads at the head
  assign ram_addr = ADDR_W'(cur_ring) * ADDR_W'(RING_DEPTH)
                  + ADDR_W'(do_push ? wr_ptr_q[cur_ring] : rd_ptr_q[cur_ring]);

  mcdf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && do_push),
    .addr_i  (ram_addr),
    .wdata_i (byte_in_i),
    .rdata_o (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && do_pop) state_d = ST_READ;
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // slot table and ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      for (int i = 0; i < SLOTS; i++) owner_q[i] <= '0;
      for (int r = 0; r < RINGS; r++) begin
        wr_ptr_q[r] <= '0;
        rd_ptr_q[r] <= '0;
        cnt_q[r]    <= '0;
      end
    end else if (in_acc) begin
      if (do_claim) begin
        used_q[free_idx]               <= 1'b1;
        owner_q[free_idx]              <= '0;
        wr_ptr_q[{free_idx, 1'b0}]     <= '0;
        rd_ptr_q[{free_idx, 1'b0}]     <= '0;
        cnt_q[{free_idx, 1'b0}]        <= '0;
        wr_ptr_q[{free_idx, 1'b1}]     <= '0;
        rd_ptr_q[{free_idx, 1'b1}]     <= '0;
        cnt_q[{free_idx, 1'b1}]        <= '0;
      end
      if (do_release) begin
        used_q[slot_idx]               <= 1'b0;
        owner_q[slot_idx]              <= '0;
        wr_ptr_q[{slot_idx, 1'b0}]     <= '0;
        rd_ptr_q[{slot_idx, 1'b0}]     <= '0;
        cnt_q[{slot_idx, 1'b0}]        <= '0;
        wr_ptr_q[{slot_idx, 1'b1}]     <= '0;
        rd_ptr_q[{slot_idx, 1'b1}]     <= '0;
        cnt_q[{slot_idx, 1'b1}]        <= '0;
      end
      if (do_attach) begin
        owner_q[slot_idx] <= owner_id_i;
      end
      if (do_detach) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (used_q[i] && owner_q[i] == owner_id_i) owner_q[i] <= '0;
        end
      end
      if (do_push) begin
        wr_ptr_q[cur_ring] <= ptr_next(wr_ptr_q[cur_ring]);
        cnt_q[cur_ring]    <= cur_cnt + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q[cur_ring] <= ptr_next(rd_ptr_q[cur_ring]);
        cnt_q[cur_ring]    <= cur_cnt - 1'b1;
      end
    end
  end

  // response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_READ) begin
      out_valid_q <= 1'b1;
    end else if (in_acc) begin
      out_valid_q <= !do_pop;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      byte_out_q <= ram_rdata;
    end else if (in_acc) begin
      ok_q       <= res_ok;
      slot_out_q <= res_slot;
      byte_out_q <= '0;
      is_open_q  <= res_iso;
      attached_q <= res_att;
      c0_q       <= res_c0;
      c1_q       <= res_c1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign ok_o             = ok_q;
  assign slot_out_o       = slot_out_q;
  assign byte_out_o       = byte_out_q;
  assign is_open_o        = is_open_q;
  assign attached_o       = attached_q;
  assign to_slave_count_o = c0_q;
  assign to_host_count_o  = c1_q;

endmodule
